// ----- sv/sparse_random_projection_sign_macros.svh -----
// assertion helpers, empty in synthesis
`ifndef SPARSE_RANDOM_PROJECTION_SIGN_MACROS_SVH
`define SPARSE_RANDOM_PROJECTION_SIGN_MACROS_SVH

`ifndef SYNTHESIS

`define SRP_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

`define SRP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`define SRP_ASSERT_NEVER(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("assertion failed");

`else

`define SRP_ASSERT_IMP(label, clk, rst, ante, cons)
`define SRP_ASSERT_NEXT(label, clk, rst, ante, cons)
`define SRP_ASSERT_NEVER(label, clk, rst, cond)

`endif

`endif

// ----- sv/srp_pkg.sv -----
package srp_pkg;

   localparam int AD_ROWS_DEF       = 32;
   localparam int USER_ROWS_DEF     = 32;
   localparam int BANK_FEATURES_DEF = 1024;
   localparam int WEIGHT_WIDTH_DEF  = 16;

   localparam int SUM_WIDTH = 32;

   // register indexes
   localparam logic [1:0] CSR_AD_COUNT   = 2'd0;
   localparam logic [1:0] CSR_USER_COUNT = 2'd1;
   localparam logic [1:0] CSR_AD_USED    = 2'd2;
   localparam logic [1:0] CSR_USER_USED  = 2'd3;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ACC,
      ST_FLUSH,
      ST_SCAN_RD,
      ST_SCAN_CHK,
      ST_FINAL
   } state_type;

   typedef struct packed {
      logic rd;
      logic acc;
      logic clr;
   } sum_cmd_type;

   function automatic logic signed [SUM_WIDTH-1:0] sat_add(
      input logic signed [SUM_WIDTH-1:0] a,
      input logic signed [SUM_WIDTH-1:0] b
   );
      logic signed [SUM_WIDTH:0] s;
      s = {a[SUM_WIDTH-1], a} + {b[SUM_WIDTH-1], b};
      if (s[SUM_WIDTH] != s[SUM_WIDTH-1]) begin
         sat_add = s[SUM_WIDTH] ? {1'b1, {(SUM_WIDTH-1){1'b0}}} : {1'b0, {(SUM_WIDTH-1){1'b1}}};
      end else begin
         sat_add = s[SUM_WIDTH-1:0];
      end
   endfunction

endpackage

// ----- sv/srp_wmem.sv -----
module srp_wmem #(
   parameter int DEPTH = srp_pkg::AD_ROWS_DEF * srp_pkg::BANK_FEATURES_DEF,
   parameter int WIDTH = srp_pkg::WEIGHT_WIDTH_DEF
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- sv/srp_sum.sv -----
module srp_sum #(
   parameter int SLOTS = srp_pkg::AD_ROWS_DEF + srp_pkg::USER_ROWS_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  srp_pkg::sum_cmd_type                   cmd,
   input  logic [$clog2(SLOTS)-1:0]               rd_addr,
   input  logic [$clog2(SLOTS)-1:0]               wr_addr,
   input  logic signed [srp_pkg::SUM_WIDTH-1:0]   addend,
   output logic signed [srp_pkg::SUM_WIDTH-1:0]   rd_data
);

   logic signed [srp_pkg::SUM_WIDTH-1:0] mem [SLOTS];
   logic [SLOTS-1:0]                     valid_ff;
   logic [SLOTS-1:0]                     valid_in;
   logic signed [srp_pkg::SUM_WIDTH-1:0] rd_q_ff;
   logic                                 rd_vld_ff;
   logic signed [srp_pkg::SUM_WIDTH-1:0] wr_data;

   // entries without a valid bit read as zero
   assign rd_data = rd_vld_ff ? rd_q_ff : '0;
   assign wr_data = srp_pkg::sat_add(rd_data, addend);

   always_comb begin
      valid_in = valid_ff;
      if (cmd.clr) begin
         valid_in = '0;
      end else if (cmd.acc) begin
         valid_in[wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         if (cmd.rd) begin
            rd_vld_ff <= valid_ff[rd_addr];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.acc) begin
         mem[wr_addr] <= wr_data;
      end
      if (cmd.rd) begin
         rd_q_ff <= mem[rd_addr];
      end
   end

endmodule

// ----- sv/sparse_random_projection_sign.sv -----
// sparse random projection with sign threshold
// req channel: func in tuser (0 weight load, 1 feature id), tlast ends an instance.
// a weight load is written in the cycle it is accepted; ready stays high.
// a feature id in the ad or user bank walks that bank's rows through one shared
// saturating adder, one row per cycle, with the weight and sum memory reads
// registered in the cycle before the write-back; ids outside both banks add
// nothing to the sums. after the last id the sums of the rows in use are
// scanned, and each positive row leaves on rsp as an index; the last result
// carries tlast, and an instance without a positive row gives one result with
// tuser set. the final result follows the scan when the output is free.
// req_tready is low from an accepted feature id until its work is done and,
// after a last id, its final result sits in the output register.
// rsp is held in an output register and one more positive row is held back to
// mark the last; a stalled receiver stalls the scan only when both are full
// and a further positive row is found.
// csr writes are always taken and belong between instances.
// reset clears the sums, the registers and the output; weights are undefined
// until loaded.
`include "sparse_random_projection_sign_macros.svh"

module sparse_random_projection_sign #(
   parameter int AD_ROWS       = srp_pkg::AD_ROWS_DEF,
   parameter int USER_ROWS     = srp_pkg::USER_ROWS_DEF,
   parameter int BANK_FEATURES = srp_pkg::BANK_FEATURES_DEF,
   parameter int WEIGHT_WIDTH  = srp_pkg::WEIGHT_WIDTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // bank[0], row[5:1], column[15:6], weight[31:16], feature_id[47:32]
   input  logic [47:0] req_tdata,
   // func[0]
   input  logic        req_tuser,
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // projected_index[5:0], zero[7:6]
   output logic [7:0]  rsp_tdata,
   // empty_res[0]
   output logic        rsp_tuser,
   output logic        rsp_tlast,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [10:0] csr_wdata
);

   localparam int MAX_ROWS   = (AD_ROWS > USER_ROWS) ? AD_ROWS : USER_ROWS;
   localparam int RCW        = $clog2(MAX_ROWS + 1);
   localparam int SLOTS      = AD_ROWS + USER_ROWS;
   localparam int SW         = $clog2(SLOTS);
   localparam int AD_DEPTH   = AD_ROWS * BANK_FEATURES;
   localparam int USER_DEPTH = USER_ROWS * BANK_FEATURES;
   localparam int AAW        = $clog2(AD_DEPTH);
   localparam int UAW        = $clog2(USER_DEPTH);
   localparam int WAW        = (AAW > UAW) ? AAW : UAW;
   localparam int SUMW       = srp_pkg::SUM_WIDTH;

   // request fields
   logic              f_bank;
   logic [4:0]        f_row;
   logic [9:0]        f_column;
   logic [15:0]       f_weight;
   logic [15:0]       f_fid;
   logic              req_acc;

   assign f_bank   = req_tdata[0];
   assign f_row    = req_tdata[5:1];
   assign f_column = req_tdata[15:6];
   assign f_weight = req_tdata[31:16];
   assign f_fid    = req_tdata[47:32];
   assign req_acc  = req_tvalid && req_tready;

   // configuration
   logic [10:0] ad_count_ff;
   logic [10:0] user_count_ff;
   logic [5:0]  ad_used_ff;
   logic [5:0]  user_used_ff;
   logic [5:0]  ad_used_sat;
   logic [5:0]  user_used_sat;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         ad_count_ff   <= '0;
         user_count_ff <= '0;
         ad_used_ff    <= '0;
         user_used_ff  <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            srp_pkg::CSR_AD_COUNT:   ad_count_ff   <= csr_wdata;
            srp_pkg::CSR_USER_COUNT: user_count_ff <= csr_wdata;
            srp_pkg::CSR_AD_USED:    ad_used_ff    <= csr_wdata[5:0];
            srp_pkg::CSR_USER_USED:  user_used_ff  <= csr_wdata[5:0];
            default: ;
         endcase
      end
   end

   assign ad_used_sat   = (ad_used_ff > 6'(AD_ROWS)) ? 6'(AD_ROWS) : ad_used_ff;
   assign user_used_sat = (user_used_ff > 6'(USER_ROWS)) ? 6'(USER_ROWS) : user_used_ff;

   // weight loads
   logic [WEIGHT_WIDTH+15:0] w_ext;
   logic [WEIGHT_WIDTH-1:0]  w_store;
   logic                     load_ok;
   logic                     ad_wr;
   logic                     user_wr;
   logic [31:0]              load_addr;

   assign w_ext     = {{WEIGHT_WIDTH{1'b0}}, f_weight};
   assign w_store   = w_ext[WEIGHT_WIDTH-1:0];
   assign load_ok   = req_acc && !req_tuser && (32'(f_column) < 32'(BANK_FEATURES));
   assign ad_wr     = load_ok && !f_bank && (32'(f_row) < 32'(AD_ROWS));
   assign user_wr   = load_ok && f_bank && (32'(f_row) < 32'(USER_ROWS));
   assign load_addr = 32'(32'(f_row) * 32'(BANK_FEATURES)) + 32'(f_column);

   // feature id decode
   logic        ad_hit;
   logic        user_hit;
   logic [15:0] uoff;
   logic [15:0] hit_col;
   logic        col_ok;

   assign ad_hit   = 17'(f_fid) < 17'(ad_count_ff);
   assign uoff     = f_fid - 16'(ad_count_ff);
   assign user_hit = !ad_hit && (17'(uoff) < 17'(user_count_ff));
   assign hit_col  = ad_hit ? f_fid : uoff;
   assign col_ok   = 32'(hit_col) < 32'(BANK_FEATURES);

   // sequencer state
   srp_pkg::state_type state_ff, state_in;
   logic              bank_ff, bank_in;
   logic              last_ff, last_in;
   logic [RCW-1:0]    cnt_ff, cnt_in;
   logic [RCW-1:0]    rl_ff, rl_in;
   logic [WAW-1:0]    wa_ff, wa_in;
   logic [SW-1:0]     slot_ff, slot_in;
   logic              s1_ff, s1_in;
   logic [SW-1:0]     s1_slot_ff, s1_slot_in;
   logic [RCW-1:0]    sc_ff, sc_in;
   logic              sp_ff, sp_in;
   logic              pend_ff, pend_in;
   logic [5:0]        pend_idx_ff, pend_idx_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [5:0]        rsp_idx_ff, rsp_idx_in;
   logic              rsp_empty_ff, rsp_empty_in;
   logic              rsp_last_ff, rsp_last_in;

   // datapath links
   srp_pkg::sum_cmd_type    sum_cmd;
   logic [SW-1:0]           sum_rd_addr;
   logic signed [SUMW-1:0]  sum_rd;
   logic signed [SUMW-1:0]  addend;
   logic                    ad_rd;
   logic                    user_rd;
   logic [WEIGHT_WIDTH-1:0] ad_rd_data;
   logic [WEIGHT_WIDTH-1:0] user_rd_data;
   logic [WEIGHT_WIDTH-1:0] w_sel;
   logic                    out_free;
   logic                    positive;
   logic [5:0]              scan_idx;
   logic [SW-1:0]           scan_slot;

   assign req_tready = (state_ff == srp_pkg::ST_IDLE);
   assign out_free  = !rsp_valid_ff || rsp_tready;
   assign positive  = !sum_rd[SUMW-1] && (sum_rd != '0);
   assign scan_idx  = 6'(sc_ff) + (sp_ff ? ad_used_sat : 6'd0);
   assign scan_slot = sp_ff ? SW'(AD_ROWS) + SW'(sc_ff) : SW'(sc_ff);
   assign w_sel     = bank_ff ? user_rd_data : ad_rd_data;
   assign addend    = SUMW'(signed'(w_sel));

   always_comb begin
      state_in     = state_ff;
      bank_in      = bank_ff;
      last_in      = last_ff;
      cnt_in       = cnt_ff;
      rl_in        = rl_ff;
      wa_in        = wa_ff;
      slot_in      = slot_ff;
      s1_in        = 1'b0;
      s1_slot_in   = slot_ff;
      sc_in        = sc_ff;
      sp_in        = sp_ff;
      pend_in      = pend_ff;
      pend_idx_in  = pend_idx_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_idx_in   = rsp_idx_ff;
      rsp_empty_in = rsp_empty_ff;
      rsp_last_in  = rsp_last_ff;
      sum_cmd      = '0;
      sum_rd_addr  = slot_ff;
      ad_rd        = 1'b0;
      user_rd      = 1'b0;

      case (state_ff)
         srp_pkg::ST_IDLE: begin
            if (req_acc && req_tuser) begin
               last_in = req_tlast;
               sc_in   = '0;
               sp_in   = 1'b0;
               bank_in = !ad_hit;
               cnt_in  = '0;
               wa_in   = WAW'(hit_col);
               slot_in = ad_hit ? '0 : SW'(AD_ROWS);
               rl_in   = ad_hit ? RCW'(AD_ROWS - 1) : RCW'(USER_ROWS - 1);
               if ((ad_hit || user_hit) && col_ok) begin
                  state_in = srp_pkg::ST_ACC;
               end else if (req_tlast) begin
                  state_in = srp_pkg::ST_SCAN_RD;
               end
            end
         end
         srp_pkg::ST_ACC: begin
            sum_cmd.rd  = 1'b1;
            sum_rd_addr = slot_ff;
            ad_rd       = !bank_ff;
            user_rd     = bank_ff;
            s1_in       = 1'b1;
            s1_slot_in  = slot_ff;
            cnt_in      = cnt_ff + 1'b1;
            wa_in       = wa_ff + WAW'(BANK_FEATURES);
            slot_in     = slot_ff + 1'b1;
            if (cnt_ff == rl_ff) begin
               state_in = srp_pkg::ST_FLUSH;
            end
         end
         srp_pkg::ST_FLUSH: begin
            state_in = last_ff ? srp_pkg::ST_SCAN_RD : srp_pkg::ST_IDLE;
         end
         srp_pkg::ST_SCAN_RD: begin
            if (!sp_ff && (6'(sc_ff) >= ad_used_sat)) begin
               sp_in = 1'b1;
               sc_in = '0;
            end else if (sp_ff && (6'(sc_ff) >= user_used_sat)) begin
               state_in = srp_pkg::ST_FINAL;
            end else begin
               sum_cmd.rd  = 1'b1;
               sum_rd_addr = scan_slot;
               state_in    = srp_pkg::ST_SCAN_CHK;
            end
         end
         srp_pkg::ST_SCAN_CHK: begin
            if (!positive) begin
               sc_in    = sc_ff + 1'b1;
               state_in = srp_pkg::ST_SCAN_RD;
            end else if (!pend_ff) begin
               pend_in     = 1'b1;
               pend_idx_in = scan_idx;
               sc_in       = sc_ff + 1'b1;
               state_in    = srp_pkg::ST_SCAN_RD;
            end else if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_idx_in   = pend_idx_ff;
               rsp_empty_in = 1'b0;
               rsp_last_in  = 1'b0;
               pend_idx_in  = scan_idx;
               sc_in        = sc_ff + 1'b1;
               state_in     = srp_pkg::ST_SCAN_RD;
            end
         end
         srp_pkg::ST_FINAL: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_idx_in   = pend_ff ? pend_idx_ff : 6'd0;
               rsp_empty_in = !pend_ff;
               rsp_last_in  = 1'b1;
               pend_in      = 1'b0;
               sum_cmd.clr  = 1'b1;
               state_in     = srp_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = srp_pkg::ST_IDLE;
         end
      endcase

      sum_cmd.acc = s1_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= srp_pkg::ST_IDLE;
         s1_ff        <= 1'b0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= '0;
         sc_ff        <= '0;
         sp_ff        <= 1'b0;
         last_ff      <= 1'b0;
         bank_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         s1_ff        <= s1_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
         cnt_ff       <= cnt_in;
         sc_ff        <= sc_in;
         sp_ff        <= sp_in;
         last_ff      <= last_in;
         bank_ff      <= bank_in;
      end
   end

   always_ff @(posedge clock) begin
      rl_ff        <= rl_in;
      wa_ff        <= wa_in;
      slot_ff      <= slot_in;
      s1_slot_ff   <= s1_slot_in;
      pend_idx_ff  <= pend_idx_in;
      rsp_idx_ff   <= rsp_idx_in;
      rsp_empty_ff <= rsp_empty_in;
      rsp_last_ff  <= rsp_last_in;
   end

   srp_wmem #(
      .DEPTH (AD_DEPTH),
      .WIDTH (WEIGHT_WIDTH)
   ) u_ad_wmem (
      .clock   (clock),
      .wr_en   (ad_wr),
      .wr_addr (AAW'(load_addr)),
      .wr_data (w_store),
      .rd_en   (ad_rd),
      .rd_addr (AAW'(wa_ff)),
      .rd_data (ad_rd_data)
   );

   srp_wmem #(
      .DEPTH (USER_DEPTH),
      .WIDTH (WEIGHT_WIDTH)
   ) u_user_wmem (
      .clock   (clock),
      .wr_en   (user_wr),
      .wr_addr (UAW'(load_addr)),
      .wr_data (w_store),
      .rd_en   (user_rd),
      .rd_addr (UAW'(wa_ff)),
      .rd_data (user_rd_data)
   );

   srp_sum #(
      .SLOTS (SLOTS)
   ) u_sum (
      .clock   (clock),
      .reset   (reset),
      .cmd     (sum_cmd),
      .rd_addr (sum_rd_addr),
      .wr_addr (s1_slot_ff),
      .addend  (addend),
      .rd_data (sum_rd)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_idx_ff};
   assign rsp_tuser  = rsp_empty_ff;
   assign rsp_tlast  = rsp_last_ff;

   // the scan never checks a row while a write-back is still in flight
   `SRP_ASSERT_NEVER(a_no_wb_in_scan, clock, reset,
      s1_ff && (state_ff == srp_pkg::ST_SCAN_CHK))
   `SRP_ASSERT_IMP(a_empty_is_last, clock, reset,
      rsp_valid_ff && rsp_empty_ff, rsp_last_ff && (rsp_idx_ff == 6'd0))
   `SRP_ASSERT_NEXT(a_final_drops_pend, clock, reset,
      (state_ff == srp_pkg::ST_FINAL) && out_free, !pend_ff && (state_ff == srp_pkg::ST_IDLE))
   `SRP_ASSERT_IMP(a_clear_only_idle_next, clock, reset,
      sum_cmd.clr, !s1_ff && !sum_cmd.rd)

endmodule
